### sv/rfr_pkg.sv
package rfr_pkg;

    // Default number of fraction bits in the levels and in the step
    localparam int FRACTION_BITS_DEF = 16;

    // Colour channels, in the order red, green, blue, alpha
    localparam int NUM_CHAN = 4;
    localparam int CHAN_W   = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ALPHA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION     = 3'd4;

    // Channel slots in the level and target arrays
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_ALPHA = 2'd3;

    // Operation codes carried in tuser
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Stream widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAXD,
        ST_STEP,
        ST_DIV_START,
        ST_ELAPSED,
        ST_DIV_TICK,
        ST_MOVE,
        ST_FINISH
    } state_t;

endpackage

### sv/rfr_div.sv
module rfr_div
    import rfr_pkg::*;
#(
    parameter int N  = 48,
    parameter int S  = 32,
    parameter int CW = 6
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [S-1:0] rem_init,
    input  logic [S-1:0] divisor,
    input  logic [CW-1:0] steps,
    output logic         done,
    output logic [N-1:0] quotient
);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] count_reg, count_next;
    logic [S-1:0]  rem_reg, rem_next;
    logic [S-1:0]  dsr_reg, dsr_next;
    logic [N-1:0]  dvd_reg, dvd_next;
    logic [S:0]    trial;
    logic [S:0]    diff;

    // One restoring step: shift in the next dividend bit and try the divisor.
    // Quotient bits enter the dividend register from the bottom.
    always_comb
    begin
        trial      = {rem_reg, dvd_reg[N-1]};
        diff       = trial - {1'b0, dsr_reg};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        dvd_next   = dvd_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = steps;
            rem_next   = rem_init;
            dsr_next   = divisor;
            dvd_next   = dividend;
        end
        else if (busy_reg)
        begin
            if (!diff[S])
            begin
                rem_next = diff[S-1:0];
                dvd_next = {dvd_reg[N-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[S-1:0];
                dvd_next = {dvd_reg[N-2:0], 1'b0};
            end
            count_next = count_reg - 1'b1;
            if (count_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        dvd_reg <= dvd_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

### sv/rfr_lane.sv
module rfr_lane
    import rfr_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic [CHAN_W+FRACTION_BITS-1:0] level,
    input  logic [CHAN_W-1:0]               target,
    input  logic [CHAN_W+FRACTION_BITS:0]   delta,
    output logic [CHAN_W+FRACTION_BITS-1:0] diff,
    output logic [CHAN_W+FRACTION_BITS-1:0] moved
);

    localparam int L = CHAN_W + FRACTION_BITS;

    logic [L-1:0] tgt;
    logic         below;
    logic         above;
    logic [L:0]   sum;

    // Distance from the level to the target, and the level moved toward the
    // target by delta, clamped so that it never overshoots.
    always_comb
    begin
        tgt   = L'(target) << FRACTION_BITS;
        below = level < tgt;
        above = level > tgt;
        diff  = below ? (tgt - level) : (level - tgt);
        sum   = {1'b0, level} + delta;
        moved = level;
        if (below)
        begin
            moved = (sum > {1'b0, tgt}) ? tgt : sum[L-1:0];
        end
        else if (above)
        begin
            moved = (delta >= {1'b0, diff}) ? tgt : (level - delta[L-1:0]);
        end
    end

endmodule

### sv/rgba_fade_ramp.sv
// A start transaction and a tick on a running fade may use the shared restoring divider,
// which yields one quotient bit a cycle; any other tick does not. One item is worked on at
// a time, and the next is taken once the result sits in the output register. rst_n clears
// all levels, targets, the duration, the step, the recorded time and both flags at once.
module rgba_fade_ramp
    import rfr_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // now_ms[31:0], paused[32], zero pad
    input  logic                  s_tuser,  // operation
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // red_out, green_out, blue_out, alpha_out,
                                            // fading[32], overlay_visible[33], zero pad
    // Configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int L  = CHAN_W + FRACTION_BITS;
    localparam int S  = 16 + FRACTION_BITS;
    localparam int N  = 16 + 2 * FRACTION_BITS;
    localparam int CW = $clog2(N + 1);

    state_t        state_reg, state_next;
    logic [L-1:0]  level_reg [NUM_CHAN];
    logic [L-1:0]  level_next [NUM_CHAN];
    logic [CHAN_W-1:0] target_reg [NUM_CHAN];
    logic [CHAN_W-1:0] target_next [NUM_CHAN];
    logic [15:0]   duration_reg, duration_next;
    logic [S-1:0]  step_reg, step_next;
    logic [31:0]   last_time_reg, last_time_next;
    logic          fade_active_reg, fade_active_next;
    logic          overlay_shown_reg, overlay_shown_next;
    logic [1:0]    idx_reg, idx_next;
    logic          m_tvalid_reg, m_tvalid_next;

    // Per-item working registers
    logic                  op_reg, op_next;
    logic [31:0]           now_reg, now_next;
    logic                  visible_reg, visible_next;
    logic [L-1:0]          maxd_reg, maxd_next;
    logic [L:0]            delta_reg, delta_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Shared lane and divider hookup
    logic [L-1:0]  lane_diff;
    logic [L-1:0]  lane_moved;
    logic          div_start;
    logic [N-1:0]  div_dividend;
    logic [S-1:0]  div_rem_init;
    logic [S-1:0]  div_divisor;
    logic [CW-1:0] div_steps;
    logic          div_done;
    logic [N-1:0]  div_quotient;

    logic          in_fire;
    logic          out_free;
    logic [31:0]   elapsed;
    logic [S-1:0]  elapsed_high;
    logic          all_reached;

    rfr_lane #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_lane (
        .level (level_reg[idx_reg]),
        .target(target_reg[idx_reg]),
        .delta (delta_reg),
        .diff  (lane_diff),
        .moved (lane_moved)
    );

    rfr_div #(
        .N (N),
        .S (S),
        .CW(CW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_dividend),
        .rem_init(div_rem_init),
        .divisor (div_divisor),
        .steps   (div_steps),
        .done    (div_done),
        .quotient(div_quotient)
    );

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Elapsed time and the part of the scaled elapsed time that lies above the
    // quotient width; if that part reaches the step, the delta saturates.
    assign elapsed      = now_reg - last_time_reg;
    assign elapsed_high = S'(elapsed[23:0]) << (FRACTION_BITS - 8);

    assign all_reached =
        (level_next[CH_RED][L-1:FRACTION_BITS]   == target_reg[CH_RED])   &&
        (level_next[CH_GREEN][L-1:FRACTION_BITS] == target_reg[CH_GREEN]) &&
        (level_next[CH_BLUE][L-1:FRACTION_BITS]  == target_reg[CH_BLUE])  &&
        (level_next[CH_ALPHA][L-1:FRACTION_BITS] == target_reg[CH_ALPHA]);

    // Sequencer: next state and all register updates
    always_comb
    begin
        state_next         = state_reg;
        level_next         = level_reg;
        target_next        = target_reg;
        duration_next      = duration_reg;
        step_next          = step_reg;
        last_time_next     = last_time_reg;
        fade_active_next   = fade_active_reg;
        overlay_shown_next = overlay_shown_reg;
        idx_next           = idx_reg;
        m_tvalid_next      = m_tvalid_reg;
        op_next            = op_reg;
        now_next           = now_reg;
        visible_next       = visible_reg;
        maxd_next          = maxd_reg;
        delta_next         = delta_reg;
        m_tdata_next       = m_tdata_reg;
        div_start          = 1'b0;
        div_dividend       = '0;
        div_rem_init       = '0;
        div_divisor        = step_reg;
        div_steps          = CW'(L);

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // Configuration writes
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TARGET_RED:   target_next[CH_RED]   = cfg_data[CHAN_W-1:0];
                REG_TARGET_GREEN: target_next[CH_GREEN] = cfg_data[CHAN_W-1:0];
                REG_TARGET_BLUE:  target_next[CH_BLUE]  = cfg_data[CHAN_W-1:0];
                REG_TARGET_ALPHA: target_next[CH_ALPHA] = cfg_data[CHAN_W-1:0];
                REG_DURATION:     duration_next         = cfg_data;
                default:          ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next  = s_tuser;
                    now_next = s_tdata[31:0];
                    idx_next = '0;
                    if (s_tuser == OP_START)
                    begin
                        // A hidden overlay starts its colour from black
                        if (level_reg[CH_ALPHA][L-1:FRACTION_BITS] == '0)
                        begin
                            level_next[CH_RED]   = '0;
                            level_next[CH_GREEN] = '0;
                            level_next[CH_BLUE]  = '0;
                        end
                        last_time_next   = s_tdata[31:0];
                        fade_active_next = 1'b1;
                        visible_next     = 1'b1;
                        maxd_next        = '0;
                        state_next       = ST_MAXD;
                    end
                    else
                    begin
                        visible_next = fade_active_reg || overlay_shown_reg;
                        if (!fade_active_reg)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            overlay_shown_next = 1'b1;
                            if (s_tdata[32])
                            begin
                                last_time_next = s_tdata[31:0];
                            end
                            if (step_reg == '0)
                            begin
                                for (int i = 0; i < NUM_CHAN; i++)
                                begin
                                    level_next[i] = L'(target_reg[i]) << FRACTION_BITS;
                                end
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_ELAPSED;
                            end
                        end
                    end
                end
            end

            // Largest channel distance, one channel a cycle
            ST_MAXD:
            begin
                if (lane_diff > maxd_reg)
                begin
                    maxd_next = lane_diff;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CH_ALPHA)
                begin
                    state_next = ST_STEP;
                end
            end

            // Step = (duration << 2*FRACTION_BITS) / distance; 0 for distance under 1.0
            ST_STEP:
            begin
                if (maxd_reg[L-1:FRACTION_BITS] != '0)
                begin
                    div_start    = 1'b1;
                    div_dividend = N'(duration_reg) << (2 * FRACTION_BITS);
                    div_rem_init = '0;
                    div_divisor  = S'(maxd_reg);
                    div_steps    = CW'(N);
                    state_next   = ST_DIV_START;
                end
                else
                begin
                    step_next  = '0;
                    state_next = ST_FINISH;
                end
            end

            ST_DIV_START:
            begin
                if (div_done)
                begin
                    step_next  = div_quotient[S-1:0];
                    state_next = ST_FINISH;
                end
            end

            // Saturate a long gap at one full range, else divide
            ST_ELAPSED:
            begin
                idx_next = '0;
                if (elapsed[31:24] != '0 || elapsed_high >= step_reg)
                begin
                    delta_next = (L + 1)'(1) << L;
                    state_next = ST_MOVE;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = '0;
                    div_rem_init = elapsed_high;
                    div_divisor  = step_reg;
                    div_steps    = CW'(L);
                    state_next   = ST_DIV_TICK;
                end
            end

            ST_DIV_TICK:
            begin
                if (div_done)
                begin
                    delta_next = {1'b0, div_quotient[L-1:0]};
                    if (div_quotient[L-1:0] == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_MOVE;
                    end
                end
            end

            // Advance one channel a cycle toward its target
            ST_MOVE:
            begin
                level_next[idx_reg] = lane_moved;
                idx_next            = idx_reg + 1'b1;
                if (idx_reg == CH_ALPHA)
                begin
                    last_time_next = now_reg;
                    state_next     = ST_FINISH;
                end
            end

            // Flag updates and the result, once the output register is free
            ST_FINISH:
            begin
                if (out_free)
                begin
                    if (op_reg == OP_TICK)
                    begin
                        if (overlay_shown_reg && !fade_active_reg &&
                            level_reg[CH_ALPHA][L-1:FRACTION_BITS] == '0)
                        begin
                            overlay_shown_next = 1'b0;
                        end
                        if (fade_active_reg && all_reached)
                        begin
                            fade_active_next = 1'b0;
                        end
                    end
                    m_tdata_next = {6'b0, visible_reg, fade_active_next,
                                    level_reg[CH_ALPHA][L-1:FRACTION_BITS],
                                    level_reg[CH_BLUE][L-1:FRACTION_BITS],
                                    level_reg[CH_GREEN][L-1:FRACTION_BITS],
                                    level_reg[CH_RED][L-1:FRACTION_BITS]};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Fade state, targets and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHAN; i++)
            begin
                level_reg[i]  <= '0;
                target_reg[i] <= '0;
            end
            duration_reg      <= '0;
            step_reg          <= '0;
            last_time_reg     <= '0;
            fade_active_reg   <= 1'b0;
            overlay_shown_reg <= 1'b0;
            idx_reg           <= '0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            level_reg         <= level_next;
            target_reg        <= target_next;
            duration_reg      <= duration_next;
            step_reg          <= step_next;
            last_time_reg     <= last_time_next;
            fade_active_reg   <= fade_active_next;
            overlay_shown_reg <= overlay_shown_next;
            idx_reg           <= idx_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    // Working values of the item in flight and the result payload
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        now_reg     <= now_next;
        visible_reg <= visible_next;
        maxd_reg    <= maxd_next;
        delta_reg   <= delta_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule
